// ===== rtl/fprm_pkg.sv =====
// Shared types and codes of the flash page ring manager.
// Used by the registers, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fprm_pkg;

	// operation codes carried in the func field
	localparam logic [2:0] FN_MOUNT_BEGIN = 3'd0;
	localparam logic [2:0] FN_MOUNT_PAGE  = 3'd1;
	localparam logic [2:0] FN_APPEND      = 3'd2;
	localparam logic [2:0] FN_FREE_OLDEST = 3'd3;
	localparam logic [2:0] FN_LOCATE_NTH  = 3'd4;
	localparam logic [2:0] FN_READ_OLDEST = 3'd5;
	localparam logic [2:0] FN_ERASE_REQ   = 3'd6;

	// configuration register indexes
	localparam logic REG_START_PAGE = 1'b0;
	localparam logic REG_END_PAGE   = 1'b1;

	// reset values of the configuration registers
	localparam logic [12:0] START_PAGE_RST = 13'd0;
	localparam logic [13:0] END_PAGE_RST   = 14'd8192;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture the input beat
		logic mul;   // reciprocal product and used count
		logic rem;   // sector alignment of the next free page
		logic exec;  // apply the operation to the pointers
		logic fin;   // load the result register
	} cmd_t;

endpackage

// ===== rtl/fprm_regs.sv =====
// APB configuration registers of the flash page ring manager.
// Depends on fprm_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module fprm_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [12:0] base_page,
	output logic [13:0] limit_page
);
	import fprm_pkg::*;

	logic [12:0] start_q;
	logic [13:0] end_q;
	logic        wr_en;

	// access phase write, word addressed
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_PAGE_RST;
			end_q   <= END_PAGE_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_START_PAGE: start_q <= pwdata[12:0];
				REG_END_PAGE:   end_q   <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[2])
			REG_START_PAGE: prdata = {19'd0, start_q};
			REG_END_PAGE:   prdata = {18'd0, end_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign base_page  = start_q;
	assign limit_page = end_q;

endmodule

// ===== rtl/fprm_ctrl.sv =====
// Sequencing controller of the flash page ring manager.
// Depends on fprm_pkg for the command struct; drives the datapath steps.
`timescale 1ns / 1ps

module fprm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output fprm_pkg::cmd_t    cmd
);
	import fprm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_REM  = 5'b00100,
		ST_EXEC = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// result register can take a new beat
	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (~out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/fprm_dp.sv =====
// Pointer datapath of the flash page ring manager: ring state, sector
// alignment by reciprocal multiply, operation logic and result register.
// Depends on fprm_pkg for operation codes and the command struct.
`timescale 1ns / 1ps

module fprm_dp #(
	parameter int PAGE_COUNT       = 8192,
	parameter int PAGES_PER_SECTOR = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fprm_pkg::cmd_t cmd,
	input  logic [12:0]    base_page,
	input  logic [13:0]    limit_page,
	input  logic [2:0]     func,
	input  logic           used,
	input  logic           tail_used,
	input  logic           last,
	input  logic           marker_unused,
	input  logic [12:0]    index,
	input  logic [12:0]    page_in,
	output logic [12:0]    page,
	output logic           ok,
	output logic           erase_sector,
	output logic           freed,
	output logic [12:0]    freed_page,
	output logic [13:0]    shortage,
	output logic [12:0]    used_count,
	output logic           mount_done
);
	import fprm_pkg::*;

	// reciprocal of the sector size: quotient is exact or one short
	localparam int          RECIP_SHIFT = 20;
	localparam int          RECIP_I     = (1 << RECIP_SHIFT) / PAGES_PER_SECTOR;
	localparam logic [19:0] RECIP       = 20'(RECIP_I);
	localparam logic [8:0]  PPS9        = 9'(PAGES_PER_SECTOR);
	localparam logic [13:0] PPS_W       = 14'(PAGES_PER_SECTOR);
	localparam logic [16:0] PAGE_CNT_W  = 17'(PAGE_COUNT);

	// captured input beat
	logic [2:0]  func_q;
	logic        used_q, tail_used_q, last_q, marker_unused_q;
	logic [12:0] index_q, page_in_q;

	// ring state
	logic [12:0] oldest_q, nfree_q, scan_q;
	logic        wrap_q, ofound_q, ffound_q, sfin_q;
	logic [12:0] oldest_d, nfree_d, scan_d;
	logic        wrap_d, ofound_d, ffound_d, sfin_d;

	// staged arithmetic
	logic [32:0] prod_s1;
	logic        aligned_s2;
	logic [12:0] cnt_q;

	// result of the operation and the output register
	logic [12:0] r_page_d, r_page_q, r_fpage_d, r_fpage_q;
	logic        r_ok_d, r_ok_q, r_erase_d, r_erase_q, r_freed_d, r_freed_q;
	logic [13:0] r_short_d, r_short_q;
	logic [12:0] page_q, freed_page_q, used_count_q;
	logic        ok_q, erase_q, freed_q, mount_done_q;
	logic [13:0] shortage_q;

	logic [13:0] area_end;
	logic [12:0] quot;
	logic [21:0] qprod;
	logic [13:0] rem;
	logic [13:0] sect_next, loc_sum, loc_wrap;
	logic [12:0] oldest_a, nfree_a;

	function automatic logic [12:0] step_pg(input logic [12:0] p, input logic [13:0] ae,
	                                        input logic [12:0] st);
		logic [13:0] inc;
		inc = {1'b0, p} + 14'd1;
		return (inc >= ae) ? st : inc[12:0];
	endfunction

	function automatic logic [12:0] count_pg(input logic [12:0] o, input logic [12:0] n,
	                                         input logic [13:0] ae, input logic [12:0] st);
		logic [13:0] c;
		if (o <= n)
			c = {1'b0, n} - {1'b0, o};
		else
			c = (ae - {1'b0, o}) + ({1'b0, n} - {1'b0, st});
		return c[12:0];
	endfunction

	// effective end of the area
	assign area_end = ({3'd0, limit_page} > PAGE_CNT_W) ? PAGE_CNT_W[13:0] : limit_page;

	// sector remainder of the next free page
	assign quot  = prod_s1[RECIP_SHIFT +: 13];
	assign qprod = {9'd0, quot} * {13'd0, PPS9};
	assign rem   = {1'b0, nfree_q} - qprod[13:0];

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q          <= func;
			used_q          <= used;
			tail_used_q     <= tail_used;
			last_q          <= last;
			marker_unused_q <= marker_unused;
			index_q         <= index;
			page_in_q       <= page_in;
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= {20'd0, nfree_q} * {13'd0, RECIP};
			cnt_q   <= count_pg(oldest_q, nfree_q, area_end, base_page);
		end
		if (cmd.rem)
			aligned_s2 <= (rem == 14'd0) || (rem == PPS_W);
	end

	// operation logic
	always_comb begin
		oldest_d  = oldest_q;
		nfree_d   = nfree_q;
		scan_d    = scan_q;
		wrap_d    = wrap_q;
		ofound_d  = ofound_q;
		ffound_d  = ffound_q;
		sfin_d    = sfin_q;
		r_page_d  = 13'd0;
		r_ok_d    = 1'b0;
		r_erase_d = 1'b0;
		r_freed_d = 1'b0;
		r_fpage_d = 13'd0;
		r_short_d = 14'd0;
		sect_next = {1'b0, nfree_q} + PPS_W;
		loc_sum   = {1'b0, oldest_q} + {1'b0, index_q};
		loc_wrap  = {1'b0, base_page} + (loc_sum - area_end);
		oldest_a  = oldest_q;
		nfree_a   = step_pg(nfree_q, area_end, base_page);
		case (func_q)
			FN_MOUNT_BEGIN: begin
				wrap_d   = used_q & tail_used_q;
				scan_d   = base_page;
				ofound_d = 1'b0;
				ffound_d = 1'b0;
				sfin_d   = 1'b0;
				r_ok_d   = 1'b1;
			end
			FN_MOUNT_PAGE: begin
				if (!sfin_q) begin
					r_ok_d = 1'b1;
					if (({1'b0, scan_q} < area_end) && !(ofound_q && ffound_q)) begin
						if (wrap_q) begin
							if (!used_q) begin
								if (!ffound_q) begin
									ffound_d = 1'b1;
									nfree_d  = scan_q;
								end
							end else if (ffound_q && !ofound_q) begin
								ofound_d = 1'b1;
								oldest_d = scan_q;
							end
						end else begin
							if (used_q) begin
								if (!ofound_q) begin
									ofound_d = 1'b1;
									oldest_d = scan_q;
								end
							end else if (ofound_q && !ffound_q) begin
								ffound_d = 1'b1;
								nfree_d  = scan_q;
							end
						end
					end
					if ({1'b0, scan_q} < area_end)
						scan_d = scan_q + 13'd1;
					// finish: fall back to the start page
					if (last_q) begin
						if (!ofound_d) begin
							oldest_d = base_page;
							nfree_d  = base_page;
						end else if (!ffound_d) begin
							nfree_d = base_page;
						end
						sfin_d = 1'b1;
					end
				end
			end
			FN_APPEND: begin
				r_page_d = nfree_q;
				r_ok_d   = 1'b1;
				if (aligned_s2) begin
					r_erase_d = ~marker_unused_q;
					// oldest page sits in the sector about to be erased
					if ((nfree_q < oldest_q) && ({1'b0, oldest_q} < sect_next))
						oldest_a = (sect_next >= area_end) ? base_page : sect_next[12:0];
				end
				nfree_d  = nfree_a;
				oldest_d = oldest_a;
				// ring full: free the oldest page
				if (nfree_a == oldest_a) begin
					r_freed_d = 1'b1;
					r_fpage_d = oldest_a;
					oldest_d  = step_pg(oldest_a, area_end, base_page);
				end
			end
			FN_FREE_OLDEST: begin
				r_page_d  = oldest_q;
				r_ok_d    = 1'b1;
				r_freed_d = 1'b1;
				r_fpage_d = oldest_q;
				oldest_d  = step_pg(oldest_q, area_end, base_page);
			end
			FN_LOCATE_NTH: begin
				if (index_q < cnt_q) begin
					r_page_d = (loc_sum >= area_end) ? loc_wrap[12:0] : loc_sum[12:0];
					r_ok_d   = 1'b1;
				end else begin
					r_short_d = {1'b0, index_q} - {1'b0, cnt_q} + 14'd1;
				end
			end
			FN_READ_OLDEST: begin
				if (oldest_q != nfree_q) begin
					r_page_d = oldest_q;
					r_ok_d   = 1'b1;
				end
			end
			FN_ERASE_REQ: begin
				if ((base_page <= page_in_q) && ({1'b0, page_in_q} < area_end) &&
				    (page_in_q == oldest_q)) begin
					r_page_d  = oldest_q;
					r_ok_d    = 1'b1;
					r_freed_d = 1'b1;
					r_fpage_d = oldest_q;
					oldest_d  = step_pg(oldest_q, area_end, base_page);
				end
			end
			default: ;
		endcase
	end

	// ring state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= 13'd0;
			nfree_q  <= 13'd0;
			scan_q   <= 13'd0;
			wrap_q   <= 1'b0;
			ofound_q <= 1'b0;
			ffound_q <= 1'b0;
			sfin_q   <= 1'b0;
		end else if (cmd.exec) begin
			oldest_q <= oldest_d;
			nfree_q  <= nfree_d;
			scan_q   <= scan_d;
			wrap_q   <= wrap_d;
			ofound_q <= ofound_d;
			ffound_q <= ffound_d;
			sfin_q   <= sfin_d;
		end
	end

	// operation result, then output register with the updated count
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			r_page_q  <= r_page_d;
			r_ok_q    <= r_ok_d;
			r_erase_q <= r_erase_d;
			r_freed_q <= r_freed_d;
			r_fpage_q <= r_fpage_d;
			r_short_q <= r_short_d;
		end
		if (cmd.fin) begin
			page_q       <= r_page_q;
			ok_q         <= r_ok_q;
			erase_q      <= r_erase_q;
			freed_q      <= r_freed_q;
			freed_page_q <= r_fpage_q;
			shortage_q   <= r_short_q;
			used_count_q <= count_pg(oldest_q, nfree_q, area_end, base_page);
			mount_done_q <= sfin_q;
		end
	end

	assign page         = page_q;
	assign ok           = ok_q;
	assign erase_sector = erase_q;
	assign freed        = freed_q;
	assign freed_page   = freed_page_q;
	assign shortage     = shortage_q;
	assign used_count   = used_count_q;
	assign mount_done   = mount_done_q;

endmodule

// ===== rtl/flash_page_ring_manager.sv =====
// Each input beat passes the controller's step sequence (capture,
// reciprocal multiply, remainder, pointer update, result load) before
// its result is valid; one item is in work at a time.
// Input is stalled while an item is in work; the result register lets the
// next item start while a result waits. Reset clears pointers and flags.
`timescale 1ns / 1ps

module flash_page_ring_manager #(
	parameter int PAGE_COUNT       = 8192,
	parameter int PAGES_PER_SECTOR = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic        used,
	input  logic        tail_used,
	input  logic        last,
	input  logic        marker_unused,
	input  logic [12:0] index,
	input  logic [12:0] page_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] page,
	output logic        ok,
	output logic        erase_sector,
	output logic        freed,
	output logic [12:0] freed_page,
	output logic [13:0] shortage,
	output logic [12:0] used_count,
	output logic        mount_done
);
	import fprm_pkg::*;

	cmd_t        cmd;
	logic [12:0] base_page;
	logic [13:0] limit_page;

	// configuration registers
	fprm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.base_page  (base_page),
		.limit_page (limit_page)
	);

	// step sequencer
	fprm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// pointer datapath
	fprm_dp #(
		.PAGE_COUNT       (PAGE_COUNT),
		.PAGES_PER_SECTOR (PAGES_PER_SECTOR)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.base_page     (base_page),
		.limit_page    (limit_page),
		.func          (func),
		.used          (used),
		.tail_used     (tail_used),
		.last          (last),
		.marker_unused (marker_unused),
		.index         (index),
		.page_in       (page_in),
		.page          (page),
		.ok            (ok),
		.erase_sector  (erase_sector),
		.freed         (freed),
		.freed_page    (freed_page),
		.shortage      (shortage),
		.used_count    (used_count),
		.mount_done    (mount_done)
	);

endmodule

// ===== rtl/fprm_checker.sv =====
// Port-level checks of the flash page ring manager, bound to the top level.
// Depends on the top level's port names only.
`timescale 1ns / 1ps

module fprm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] page,
	input logic        ok,
	input logic        erase_sector,
	input logic        freed,
	input logic [13:0] shortage
);

	// one item in work at a time: accept is followed by stall
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted beat");

	// an erase is only flagged by a successful append
	a_erase_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && erase_sector |-> ok)
		else $error("erase flagged on failed operation");

	// freeing only happens on successful operations
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && freed |-> ok)
		else $error("page freed on failed operation");

	// a shortage means a failed locate with no page
	a_shortage: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (shortage != 14'd0) |-> !ok && (page == 13'd0))
		else $error("shortage with a located page");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(page))
		else $error("stalled result beat changed");

endmodule

bind flash_page_ring_manager fprm_checker u_chk (.*);
